// ----- hdl/bvm_pkg.sv -----
`timescale 1ns / 1ps
// Package for the ballistic vertical motion block.
// Holds the request and result payload types, opcodes and register indexes.
package bvm_pkg;

	typedef logic signed [31:0] fx_t;

	localparam logic [2:0] OP_SET_POS  = 3'd0;
	localparam logic [2:0] OP_START    = 3'd1;
	localparam logic [2:0] OP_START_HT = 3'd2;
	localparam logic [2:0] OP_TICK     = 3'd3;
	localparam logic [2:0] OP_STOP     = 3'd4;
	localparam logic [2:0] OP_PAUSE    = 3'd5;

	localparam logic [2:0] REG_DEF_GRAVITY  = 3'd0;
	localparam logic [2:0] REG_DEF_LAUNCH   = 3'd1;
	localparam logic [2:0] REG_DEF_TERMINAL = 3'd2;
	localparam logic [2:0] REG_ASC_GRAVITY  = 3'd3;
	localparam logic [2:0] REG_ASC_LAUNCH   = 3'd4;

	localparam fx_t MINUS_ONE = -32'sd1;
	localparam logic [63:0] ROUND_HALF = 64'd524288;
	localparam logic [15:0] FALL_MAX = 16'hFFFF;

	typedef struct packed {
		logic [2:0] opcode;
		fx_t        start_speed;
		fx_t        target_height;
		fx_t        fall_accel;
		fx_t        speed_limit;
		fx_t        new_position;
		fx_t        new_height;
		logic       pause_flag;
	} in_t;

	typedef struct packed {
		fx_t         position;
		fx_t         height;
		fx_t         speed;
		logic        moving;
		logic        paused;
		logic [15:0] fall_ticks;
		fx_t         launch_position;
		logic        landed;
		logic        ascent_capped;
	} out_t;

endpackage

// ----- hdl/bvm_in_if.sv -----
`timescale 1ns / 1ps
// Request channel interface of the ballistic vertical motion block.
// Depends on bvm_pkg for the payload type.
interface bvm_in_if;
	logic         valid;
	logic         ready;
	bvm_pkg::in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/bvm_out_if.sv -----
`timescale 1ns / 1ps
// Result channel interface of the ballistic vertical motion block.
// Depends on bvm_pkg for the payload type.
interface bvm_out_if;
	logic          valid;
	logic          ready;
	bvm_pkg::out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/ballistic_vertical_motion.sv -----
`timescale 1ns / 1ps
// Ballistic vertical motion of one body in 20.12 fixed point, single request at a time.
// Most requests go from idle straight to the done state; start to height first runs the
// ascent loop, one step a cycle up to MAX_ASCENT_STEPS, then the bit-serial divider if
// the ascent overshot. A request is taken only in the idle state, and one is taken while
// the previous result still waits. Asynchronous active-low reset clears the settings,
// body state and sequencer, not working registers; launch position resets to minus one.
// Depends on bvm_pkg, bvm_in_if and bvm_out_if.
module ballistic_vertical_motion #(
	parameter int MAX_ASCENT_STEPS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	bvm_in_if.sink      item,
	bvm_out_if.source   result,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data
);

	localparam int CntW = $clog2(MAX_ASCENT_STEPS + 1);

	// One-hot sequencer states.
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ASC  = 7'b0000010,
		ST_DIV  = 7'b0000100,
		ST_QUO  = 7'b0001000,
		ST_MUL  = 7'b0010000,
		ST_ADJ  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	bvm_pkg::fx_t def_gravity_q, def_launch_q, def_terminal_q, asc_gravity_q, asc_launch_q;

	// Body state.
	bvm_pkg::fx_t pos_q, height_q, speed_q, accel_q, limit_q, launch_q;
	logic         active_q, pause_q;
	logic [15:0]  fall_q;

	// Latched request and ascent working registers.
	bvm_pkg::in_t req_q;
	bvm_pkg::fx_t v_q, g_q, s_q, q_q, prod_q;
	logic [CntW-1:0] n_q;
	logic         capped_q;
	logic [63:0]  div_q;
	logic [31:0]  rem_q, dvsr_q;
	logic         neg_q;
	logic [5:0]   bit_q;

	logic         out_valid_q;
	bvm_pkg::out_t out_q;

	assign item.ready   = (state_q == ST_IDLE);
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	wire accept   = item.valid && item.ready;
	wire out_free = !out_valid_q || result.ready;

	// Ascent step: velocity gains gravity, the running height gains velocity.
	bvm_pkg::fx_t v_step, s_step;
	logic [CntW-1:0] n_step;
	assign v_step = v_q + g_q;
	assign s_step = s_q + v_step;
	assign n_step = n_q + 1'b1;

	// Restoring division step on magnitudes.
	logic [32:0] div_trial;
	logic        div_fit;
	assign div_trial = {rem_q, div_q[63]};
	assign div_fit   = div_trial >= {1'b0, dvsr_q};

	// Signed quotient, rounded to 20.12.
	logic [63:0] q_signed, q_round;
	assign q_signed = neg_q ? (~div_q + 64'd1) : div_q;
	assign q_round  = q_signed + bvm_pkg::ROUND_HALF;

	// Product divided by 4096, truncating toward zero.
	logic [31:0] prod_mag, adj;
	assign prod_mag = prod_q[31] ? (~prod_q + 32'd1) : prod_q;
	assign adj      = prod_q[31] ? ~(prod_mag >> 12) + 32'd1 : (prod_q >>> 12);

	// Start resolution shared by both start opcodes.
	bvm_pkg::fx_t st_v_in, st_g_in, st_v, st_g, st_lim;
	assign st_v_in = (req_q.opcode == bvm_pkg::OP_START) ? req_q.start_speed : v_q;
	assign st_g_in = (req_q.opcode == bvm_pkg::OP_START) ? req_q.fall_accel : g_q;
	assign st_v    = (st_v_in == 32'sd0) ? -def_gravity_q :
	                 (st_v_in == bvm_pkg::MINUS_ONE) ? def_launch_q : st_v_in;
	assign st_g    = (st_g_in == bvm_pkg::MINUS_ONE) ? def_gravity_q : st_g_in;
	assign st_lim  = (req_q.speed_limit == bvm_pkg::MINUS_ONE) ? def_terminal_q
	                                                            : req_q.speed_limit;

	// Tick arithmetic.
	bvm_pkg::fx_t tk_h, tk_p, tk_v, tk_vc;
	logic         tk_land;
	assign tk_h    = height_q + speed_q;
	assign tk_p    = pos_q + speed_q;
	assign tk_land = (speed_q <= 32'sd0) && (tk_h <= 32'sd0);
	assign tk_v    = speed_q - accel_q;
	assign tk_vc   = (limit_q[31] && (tk_v < limit_q)) ? limit_q : tk_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_gravity_q  <= '0;
			def_launch_q   <= '0;
			def_terminal_q <= '0;
			asc_gravity_q  <= '0;
			asc_launch_q   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				bvm_pkg::REG_DEF_GRAVITY:  def_gravity_q  <= wr_data;
				bvm_pkg::REG_DEF_LAUNCH:   def_launch_q   <= wr_data;
				bvm_pkg::REG_DEF_TERMINAL: def_terminal_q <= wr_data;
				bvm_pkg::REG_ASC_GRAVITY:  asc_gravity_q  <= wr_data;
				bvm_pkg::REG_ASC_LAUNCH:   asc_launch_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// Working registers carry no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					req_q    <= item.data;
					capped_q <= 1'b0;
					v_q      <= (item.data.target_height == bvm_pkg::MINUS_ONE) ? asc_launch_q
					                                                           : '0;
					g_q      <= ((item.data.target_height != 32'sd0) &&
					             (item.data.fall_accel == bvm_pkg::MINUS_ONE)) ? asc_gravity_q
					                                                           : item.data.fall_accel;
					s_q      <= '0;
					n_q      <= '0;
				end
			end
			ST_ASC: begin
				v_q <= v_step;
				s_q <= s_step;
				n_q <= n_step;
				if (!((s_step < req_q.target_height) &&
				      (n_step < CntW'(MAX_ASCENT_STEPS)))) begin
					capped_q <= s_step < req_q.target_height;
					div_q    <= {s_step - req_q.target_height, 32'd0};
					rem_q    <= '0;
					dvsr_q   <= v_step[31] ? (~v_step + 32'd1) : v_step;
					neg_q    <= v_step[31];
					bit_q    <= '0;
					q_q      <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= div_fit ? 32'(div_trial - {1'b0, dvsr_q}) : div_trial[31:0];
				div_q <= {div_q[62:0], div_fit};
				bit_q <= bit_q + 6'd1;
			end
			ST_QUO: begin
				if (dvsr_q != 32'd0)
					q_q <= q_round[51:20];
			end
			ST_MUL: prod_q <= 32'(g_q * q_q);
			ST_ADJ: v_q <= v_q - adj;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			height_q    <= '0;
			speed_q     <= '0;
			accel_q     <= '0;
			limit_q     <= '0;
			active_q    <= 1'b0;
			pause_q     <= 1'b0;
			fall_q      <= '0;
			launch_q    <= bvm_pkg::MINUS_ONE;
		end else begin
			// A result taken in the same cycle as a new one is written stays valid.
			if (result.valid && result.ready && !((state_q == ST_DONE) && out_free))
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ((item.data.opcode == bvm_pkg::OP_START_HT) &&
						            (item.data.target_height != 32'sd0) &&
						            (item.data.target_height != bvm_pkg::MINUS_ONE))
						           ? ST_ASC : ST_DONE;
				end
				ST_ASC: begin
					if (!((s_step < req_q.target_height) &&
					      (n_step < CntW'(MAX_ASCENT_STEPS))))
						state_q <= ((s_step - req_q.target_height) > 32'sd0) ? ST_DIV : ST_DONE;
				end
				ST_DIV: if (bit_q == 6'd63) state_q <= ST_QUO;
				ST_QUO: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ADJ;
				ST_ADJ: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						bvm_pkg::fx_t n_pos, n_h, n_v, n_launch;
						logic n_act, n_pause, n_land;
						logic [15:0] n_fall;
						n_pos = pos_q; n_h = height_q; n_v = speed_q; n_launch = launch_q;
						n_act = active_q; n_pause = pause_q; n_fall = fall_q; n_land = 1'b0;
						case (req_q.opcode)
							bvm_pkg::OP_SET_POS: begin
								n_pos = req_q.new_position;
								n_h   = req_q.new_height;
							end
							bvm_pkg::OP_START, bvm_pkg::OP_START_HT: begin
								n_v = st_v; n_act = 1'b1; n_pause = 1'b0;
								n_fall = '0; n_launch = pos_q;
								accel_q <= st_g;
								limit_q <= st_lim;
							end
							bvm_pkg::OP_TICK: begin
								if (!pause_q && active_q) begin
									n_pos = tk_p; n_h = tk_h;
									if (speed_q[31] && (fall_q != bvm_pkg::FALL_MAX))
										n_fall = fall_q + 16'd1;
									if (tk_land) begin
										n_pos = tk_p - tk_h; n_h = '0;
										n_act = 1'b0; n_pause = 1'b0;
										n_launch = bvm_pkg::MINUS_ONE; n_land = 1'b1;
									end else begin
										n_v = tk_vc;
									end
								end
							end
							bvm_pkg::OP_STOP: begin
								n_act = 1'b0; n_pause = 1'b0; n_launch = bvm_pkg::MINUS_ONE;
							end
							bvm_pkg::OP_PAUSE: n_pause = req_q.pause_flag;
							default: ;
						endcase
						pos_q <= n_pos; height_q <= n_h; speed_q <= n_v; launch_q <= n_launch;
						active_q <= n_act; pause_q <= n_pause; fall_q <= n_fall;
						out_q.position        <= n_pos;
						out_q.height          <= n_h;
						out_q.speed           <= n_v;
						out_q.moving          <= n_act;
						out_q.paused          <= n_pause;
						out_q.fall_ticks      <= n_fall;
						out_q.launch_position <= n_launch;
						out_q.landed          <= n_land;
						out_q.ascent_capped   <= (req_q.opcode == bvm_pkg::OP_START_HT) && capped_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The ascent step counter never runs past its cap.
	a_step_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ASC) |-> (n_q < CntW'(MAX_ASCENT_STEPS)))
		else $error("ascent step counter past cap");

	// A body at rest always reports a cleared launch position.
	a_rest_launch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.moving) |-> (out_q.launch_position == bvm_pkg::MINUS_ONE))
		else $error("launch position set while at rest");

	// A landing leaves the body on the ground and stopped.
	a_landing: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.landed) |-> (!out_q.moving && (out_q.height == 32'sd0)))
		else $error("landing left body moving or airborne");

	// An accepted request always leaves the idle state.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("sequencer stayed idle after a request");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for ballistic_vertical_motion: drives requests, predicts every result.
// Depends on bvm_pkg, bvm_in_if, bvm_out_if and the block itself.
module tb;

	localparam int ASCENT_CAP = 1024;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [2:0] wr_index;
	logic [31:0] wr_data;

	bvm_in_if item_ch ();
	bvm_out_if result_ch ();

	ballistic_vertical_motion #(.MAX_ASCENT_STEPS(ASCENT_CAP)) dut (
		.clk(clk), .arst_n(arst_n), .item(item_ch.sink), .result(result_ch.source),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	// The predictor's own copy of the body state and of the five settings.
	bvm_pkg::fx_t def_gravity, def_launch, def_terminal, asc_gravity, asc_launch;
	bvm_pkg::fx_t body_pos, body_height, body_speed, body_accel, body_limit, body_launch;
	logic body_active, body_paused;
	logic [15:0] body_fall;

	bvm_pkg::out_t motion_expected[$];
	int mismatches;
	int results_seen;
	int send_idle_pct;
	int recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous upper bound: every request could be a capped ascent under heavy stalls.
	initial begin
		#50ms;
		$display("timeout with %0d results outstanding", motion_expected.size());
		$display("tb: FAIL");
		$finish;
	end

	// Twelve-bit fractional quotient e/v, rounded to nearest; zero divisor gives zero.
	function automatic logic [31:0] fx_quotient(logic [31:0] e, logic [31:0] v);
		logic signed [63:0] num;
		logic signed [63:0] den;
		logic signed [63:0] q;
		if (v == 32'd0)
			return 32'd0;
		num = {e, 32'd0};
		den = $signed(v);
		q = num / den;
		q = q + 64'sd524288;
		return 32'(q >>> 20);
	endfunction

	// Signed division by 4096 truncating towards zero.
	function automatic logic [31:0] trunc_div4096(logic [31:0] p);
		logic [31:0] mag;
		if (p[31]) begin
			mag = (~p + 32'd1) / 32'd4096;
			return ~mag + 32'd1;
		end
		return p / 32'd4096;
	endfunction

	task automatic launch_body(bvm_pkg::fx_t v, bvm_pkg::fx_t g, bvm_pkg::fx_t lim);
		if (v == 0)
			v = -def_gravity;
		else if (v == bvm_pkg::MINUS_ONE)
			v = def_launch;
		body_speed = v;
		body_accel = (g == bvm_pkg::MINUS_ONE) ? def_gravity : g;
		body_limit = (lim == bvm_pkg::MINUS_ONE) ? def_terminal : lim;
		body_active = 1'b1;
		body_paused = 1'b0;
		body_fall = '0;
		body_launch = body_pos;
	endtask

	task automatic halt_body();
		body_active = 1'b0;
		body_paused = 1'b0;
		body_launch = bvm_pkg::MINUS_ONE;
	endtask

	// Applies one request to the predicted state and returns the result it should give.
	task automatic predict_motion(input bvm_pkg::in_t req, output bvm_pkg::out_t res);
		bvm_pkg::fx_t v, g, s, e;
		int n;
		logic landed, capped;
		landed = 1'b0;
		capped = 1'b0;
		case (req.opcode)
			bvm_pkg::OP_SET_POS: begin
				body_pos = req.new_position;
				body_height = req.new_height;
			end
			bvm_pkg::OP_START: launch_body(req.start_speed, req.fall_accel, req.speed_limit);
			bvm_pkg::OP_START_HT: begin
				v = 0;
				g = req.fall_accel;
				if (req.target_height != 0) begin
					if (g == bvm_pkg::MINUS_ONE)
						g = asc_gravity;
					if (req.target_height == bvm_pkg::MINUS_ONE) begin
						v = asc_launch;
					end else begin
						s = 0;
						n = 0;
						do begin
							v = v + g;
							s = s + v;
							n++;
						end while (s < req.target_height && n < ASCENT_CAP);
						capped = s < req.target_height;
						e = s - req.target_height;
						// Trim the overshoot of the last whole step.
						if (e > 0)
							v = v - trunc_div4096(g * fx_quotient(e, v));
					end
				end
				launch_body(v, g, req.speed_limit);
			end
			bvm_pkg::OP_TICK: begin
				if (!body_paused && body_active) begin
					body_height = body_height + body_speed;
					body_pos = body_pos + body_speed;
					if (body_speed < 0 && body_fall != bvm_pkg::FALL_MAX)
						body_fall++;
					if (body_speed <= 0 && body_height <= 0) begin
						body_pos = body_pos - body_height;
						body_height = 0;
						halt_body();
						landed = 1'b1;
					end else begin
						body_speed = body_speed - body_accel;
						if (body_limit < 0 && body_speed < body_limit)
							body_speed = body_limit;
					end
				end
			end
			bvm_pkg::OP_STOP: halt_body();
			bvm_pkg::OP_PAUSE: body_paused = req.pause_flag;
			default: ;
		endcase
		res.position = body_pos;
		res.height = body_height;
		res.speed = body_speed;
		res.moving = body_active;
		res.paused = body_paused;
		res.fall_ticks = body_fall;
		res.launch_position = body_launch;
		res.landed = landed;
		res.ascent_capped = capped;
	endtask

	// Sends one request; the expectation is queued at the edge that accepts it.
	// Valid is left high so that the next request can follow at once; drain lowers it.
	task automatic send_request(bvm_pkg::in_t req);
		bvm_pkg::out_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= req;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		predict_motion(req, res);
		motion_expected.push_back(res);
		@(negedge clk);
	endtask

	// The checker: compares each accepted result against the oldest expectation.
	always @(posedge clk) begin
		bvm_pkg::out_t want;
		bvm_pkg::out_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			results_seen++;
			if (motion_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
			end else begin
				want = motion_expected.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// Receiver stalls are redrawn at every falling edge.
	always @(negedge clk)
		result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic write_setting(logic [2:0] idx, bvm_pkg::fx_t value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
		case (idx)
			bvm_pkg::REG_DEF_GRAVITY: def_gravity = value;
			bvm_pkg::REG_DEF_LAUNCH: def_launch = value;
			bvm_pkg::REG_DEF_TERMINAL: def_terminal = value;
			bvm_pkg::REG_ASC_GRAVITY: asc_gravity = value;
			bvm_pkg::REG_ASC_LAUNCH: asc_launch = value;
			default: ;
		endcase
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (motion_expected.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_all(bvm_pkg::fx_t g, bvm_pkg::fx_t l, bvm_pkg::fx_t t,
		bvm_pkg::fx_t ag, bvm_pkg::fx_t al);
		drain();
		write_setting(bvm_pkg::REG_DEF_GRAVITY, g);
		write_setting(bvm_pkg::REG_DEF_LAUNCH, l);
		write_setting(bvm_pkg::REG_DEF_TERMINAL, t);
		write_setting(bvm_pkg::REG_ASC_GRAVITY, ag);
		write_setting(bvm_pkg::REG_ASC_LAUNCH, al);
	endtask

	function automatic bvm_pkg::in_t blank_request(logic [2:0] op);
		bvm_pkg::in_t r;
		r = '0;
		r.opcode = op;
		return r;
	endfunction

	// Wide random value, biased now and then towards the special and extreme codes.
	function automatic bvm_pkg::fx_t wild_value();
		case ($urandom_range(7))
			0: return bvm_pkg::MINUS_ONE;
			1: return 0;
			2: return 32'sh7FFFFFFF;
			3: return 32'sh80000000;
			default: return $urandom;
		endcase
	endfunction

	// Realistic magnitudes so that flights last several ticks.
	function automatic bvm_pkg::fx_t modest(int lo, int hi);
		return $urandom_range(hi - lo) + lo;
	endfunction

	task automatic test_directed();
		bvm_pkg::in_t r;
		r = blank_request(bvm_pkg::OP_TICK);
		send_request(r);                         // tick while idle does nothing
		r = blank_request(bvm_pkg::OP_SET_POS);
		r.new_position = 32'sh7FFFFFFF;
		r.new_height = 32'sh80000000;
		send_request(r);
		r = blank_request(bvm_pkg::OP_SET_POS);
		r.new_position = 32'sd40960;
		r.new_height = 32'sd20480;
		send_request(r);
		r = blank_request(bvm_pkg::OP_START);    // zero speed takes minus default gravity
		r.fall_accel = bvm_pkg::MINUS_ONE;
		r.speed_limit = bvm_pkg::MINUS_ONE;
		send_request(r);
		repeat (3) send_request(blank_request(bvm_pkg::OP_TICK));
		r = blank_request(bvm_pkg::OP_PAUSE);
		r.pause_flag = 1'b1;
		send_request(r);
		send_request(blank_request(bvm_pkg::OP_TICK));    // paused tick holds still
		r.pause_flag = 1'b0;
		send_request(r);
		r = blank_request(bvm_pkg::OP_START);    // minus one takes the default launch
		r.start_speed = bvm_pkg::MINUS_ONE;
		r.fall_accel = 32'sd400;
		r.speed_limit = -32'sd1000;
		send_request(r);
		repeat (4) send_request(blank_request(bvm_pkg::OP_TICK));
		send_request(blank_request(bvm_pkg::OP_STOP));
		r = blank_request(bvm_pkg::OP_START_HT); // zero height launches at minus default gravity
		r.fall_accel = bvm_pkg::MINUS_ONE;
		send_request(r);
		r.target_height = bvm_pkg::MINUS_ONE;    // minus one height takes ascent default
		send_request(r);
		r.target_height = 32'sd81920;
		r.fall_accel = 32'sd300;
		send_request(r);
		r.target_height = 32'sh7FFFFFFF;         // unreachable: step cap
		r.fall_accel = 32'sd1;
		send_request(r);
		r.fall_accel = 32'sd0;                   // zero velocity in the trim divide
		r.target_height = -32'sd5;
		send_request(r);
		send_request(blank_request(3'd6));
		send_request(blank_request(3'd7));
		send_request(blank_request(bvm_pkg::OP_STOP));
	endtask

	// Random requests of any opcode, ticks favoured, operands mostly modest and now and then wild.
	task automatic test_random(int count);
		bvm_pkg::in_t r;
		int sent;
		sent = 0;
		while (sent < count) begin
			r.opcode = 3'($urandom_range(7));
			r.start_speed = $urandom_range(3) == 0 ? wild_value() : modest(-4000, 30000);
			r.target_height = $urandom_range(3) == 0 ? wild_value() : modest(-1000, 200000);
			r.fall_accel = $urandom_range(3) == 0 ? wild_value() : modest(-50, 3000);
			r.speed_limit = $urandom_range(2) == 0 ? wild_value() : modest(-40000, 1000);
			r.new_position = $urandom_range(3) == 0 ? wild_value() : modest(-90000, 90000);
			r.new_height = $urandom_range(3) == 0 ? wild_value() : modest(-2000, 90000);
			r.pause_flag = 1'($urandom_range(1));
			if ($urandom_range(9) < 4)
				r.opcode = bvm_pkg::OP_TICK;
			send_request(r);
			sent++;
		end
	endtask

	task automatic test_settings_extremes();
		set_all(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
		test_random(30);
		set_all(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
		test_random(30);
		drain();
		write_setting(3'd7, 32'shDEADBEEF);      // out-of-range index is ignored
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		results_seen = 0;
		{def_gravity, def_launch, def_terminal, asc_gravity, asc_launch} = '0;
		{body_pos, body_height, body_speed, body_accel, body_limit} = '0;
		body_active = 1'b0;
		body_paused = 1'b0;
		body_fall = '0;
		body_launch = bvm_pkg::MINUS_ONE;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		set_all(32'sd410, 32'sd20480, -32'sd30000, 32'sd350, 32'sd16000);
		test_directed();
		test_settings_extremes();
		set_all(32'sd600, 32'sd12000, -32'sd8000, 32'sd200, 32'sd9000);
		test_random(100);
		send_idle_pct = 53;
		test_random(90);
		send_idle_pct = 0;
		recv_stall_pct = 53;
		test_random(90);
		send_idle_pct = 15;
		recv_stall_pct = 15;
		test_random(90);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		repeat (100) @(negedge clk);

		$display("covered all opcodes, all five settings incl. extremes, %0d results checked",
			results_seen);
		if (mismatches == 0 && motion_expected.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
